[rtl/pht_pkg.sv]
`default_nettype none
package pht_pkg;

	localparam int TW = 48;
	localparam int FRAC_BITS_DEF = 20;
	localparam int AW = 6;

	localparam logic [TW-1:0] T_MAX = {1'b0, {(TW-1){1'b1}}};
	localparam logic [TW-1:0] T_MIN = {1'b1, {(TW-1){1'b0}}};

	localparam logic [2:0] REG_DURATION   = 3'd0;
	localparam logic [2:0] REG_LOOP_START = 3'd1;
	localparam logic [2:0] REG_LOOP_END   = 3'd2;
	localparam logic [2:0] REG_LOOP_EN    = 3'd3;
	localparam logic [2:0] REG_PLAY_RATE  = 3'd4;
	localparam logic [2:0] REG_OFFLINE    = 3'd5;
	localparam logic [2:0] REG_FRAME_NUM  = 3'd6;
	localparam logic [2:0] REG_FRAME_DEN  = 3'd7;

	localparam logic [3:0] OP_PLAY          = 4'd0;
	localparam logic [3:0] OP_PAUSE         = 4'd1;
	localparam logic [3:0] OP_TOGGLE        = 4'd2;
	localparam logic [3:0] OP_STOP          = 4'd3;
	localparam logic [3:0] OP_STOP_IN_PLACE = 4'd4;
	localparam logic [3:0] OP_TO_START      = 4'd5;
	localparam logic [3:0] OP_SEEK          = 4'd6;
	localparam logic [3:0] OP_SEEK_REL      = 4'd7;
	localparam logic [3:0] OP_SEEK_FRAME    = 4'd8;
	localparam logic [3:0] OP_STEP          = 4'd9;
	localparam logic [3:0] OP_ADVANCE       = 4'd10;
	localparam logic [3:0] OP_FOLLOW        = 4'd11;
	localparam logic [3:0] OP_OFFLINE_POS   = 4'd12;

	localparam logic [1:0] RUN_STOPPED = 2'd0;
	localparam logic [1:0] RUN_PLAYING = 2'd1;
	localparam logic [1:0] RUN_PAUSED  = 2'd2;

	localparam logic [3:0] CMD_NONE     = 4'd0;
	localparam logic [3:0] CMD_LOAD     = 4'd1;
	localparam logic [3:0] CMD_EXEC     = 4'd2;
	localparam logic [3:0] CMD_FMUL_LD  = 4'd3;
	localparam logic [3:0] CMD_FDIV_LD  = 4'd4;
	localparam logic [3:0] CMD_FFIN     = 4'd5;
	localparam logic [3:0] CMD_TMUL_LD  = 4'd6;
	localparam logic [3:0] CMD_TDIV_LD  = 4'd7;
	localparam logic [3:0] CMD_TFIN     = 4'd8;
	localparam logic [3:0] CMD_AMUL_LD  = 4'd9;
	localparam logic [3:0] CMD_WRAP     = 4'd10;
	localparam logic [3:0] CMD_MDIV_LD  = 4'd11;
	localparam logic [3:0] CMD_MFIN     = 4'd12;
	localparam logic [3:0] CMD_MUL_STEP = 4'd13;
	localparam logic [3:0] CMD_DIV_STEP = 4'd14;

	typedef struct packed {
		logic [3:0]           op;
		logic signed [TW-1:0] time_value;
		logic signed [31:0]   frame_value;
	} pht_in_t;

	typedef struct packed {
		logic [1:0]           play_state;
		logic signed [TW-1:0] position;
		logic signed [31:0]   frame_index;
		logic                 changed;
		logic                 looped;
		logic                 reached_end;
		logic [31:0]          revision;
		logic [31:0]          jump_count;
	} pht_out_t;

	typedef struct packed {
		logic [3:0] code;
	} pht_ctl_t;

	typedef struct packed {
		logic mul_done;
		logic div_done;
		logic is_step;
		logic is_sfrm;
		logic go_adv;
		logic go_fol;
		logic wrap_loop;
	} pht_sts_t;

endpackage
`default_nettype wire

[rtl/pht_regs.sv]
`default_nettype none
module pht_regs (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    psel,
	input  logic                    penable,
	input  logic                    pwrite,
	input  logic [pht_pkg::AW-1:0]  paddr,
	input  logic [63:0]             pwdata,
	output logic [63:0]             prdata,
	output logic                    pready,
	output logic [pht_pkg::TW-2:0]  dur,
	output logic [pht_pkg::TW-2:0]  ls,
	output logic [pht_pkg::TW-2:0]  le,
	output logic                    len,
	output logic [12:0]             rate,
	output logic                    off,
	output logic [23:0]             num,
	output logic [15:0]             den
);
	import pht_pkg::*;

	localparam int TM = TW - 1;

	logic [TM-1:0] dur_q, ls_q, le_q;
	logic          len_q, off_q;
	logic [12:0]   rate_q;
	logic [23:0]   num_q;
	logic [15:0]   den_q;
	logic [2:0]    idx;
	logic          wr;

	assign idx    = paddr[AW-1:3];
	assign wr     = psel && penable && pwrite;
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dur_q  <= '0;
			ls_q   <= '0;
			le_q   <= '0;
			len_q  <= 1'b0;
			rate_q <= 13'd256;
			off_q  <= 1'b0;
			num_q  <= 24'd60;
			den_q  <= 16'd1;
		end else if (wr) begin
			case (idx)
				REG_DURATION:   dur_q  <= pwdata[TM-1:0];
				REG_LOOP_START: ls_q   <= pwdata[TM-1:0];
				REG_LOOP_END:   le_q   <= pwdata[TM-1:0];
				REG_LOOP_EN:    len_q  <= pwdata[0];
				REG_PLAY_RATE:  rate_q <= pwdata[12:0];
				REG_OFFLINE:    off_q  <= pwdata[0];
				REG_FRAME_NUM: begin
					if (pwdata[23:0] != '0) num_q <= pwdata[23:0];
				end
				REG_FRAME_DEN: begin
					if (pwdata[15:0] != '0) den_q <= pwdata[15:0];
				end
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_DURATION:   prdata = 64'(dur_q);
			REG_LOOP_START: prdata = 64'(ls_q);
			REG_LOOP_END:   prdata = 64'(le_q);
			REG_LOOP_EN:    prdata = 64'(len_q);
			REG_PLAY_RATE:  prdata = 64'(rate_q);
			REG_OFFLINE:    prdata = 64'(off_q);
			REG_FRAME_NUM:  prdata = 64'(num_q);
			REG_FRAME_DEN:  prdata = 64'(den_q);
			default:        prdata = '0;
		endcase
	end

	assign dur  = dur_q;
	assign ls   = ls_q;
	assign le   = le_q;
	assign len  = len_q;
	assign rate = rate_q;
	assign off  = off_q;
	assign num  = num_q;
	assign den  = den_q;

endmodule
`default_nettype wire

[rtl/pht_dp.sv]
`default_nettype none
module pht_dp #(
	parameter int FRAC_BITS = pht_pkg::FRAC_BITS_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  pht_pkg::pht_ctl_t       ctl,
	output pht_pkg::pht_sts_t       sts,
	input  pht_pkg::pht_in_t        req,
	output pht_pkg::pht_out_t       res,
	input  logic [pht_pkg::TW-2:0]  dur,
	input  logic [pht_pkg::TW-2:0]  ls,
	input  logic [pht_pkg::TW-2:0]  le,
	input  logic                    len,
	input  logic [12:0]             rate,
	input  logic                    off,
	input  logic [23:0]             num,
	input  logic [15:0]             den
);
	import pht_pkg::*;

	localparam int TM = TW - 1;
	localparam int W  = (TW + 24 > 49 + FRAC_BITS) ? TW + 24 : 49 + FRAC_BITS;
	localparam int DW = (TW > 24) ? TW : 24;
	localparam int CW = $clog2(W + 1);

	function automatic logic [TW-1:0] sat_add(input logic [TW-1:0] a, input logic [TW-1:0] b);
		logic [TW:0] s;
		s = {a[TW-1], a} + {b[TW-1], b};
		if (s[TW] != s[TW-1]) return s[TW] ? T_MIN : T_MAX;
		return s[TW-1:0];
	endfunction

	function automatic logic [TW-1:0] clamp_rng(input logic [TW-1:0] x, input logic offm,
		input logic [TM-1:0] d);
		if (offm) return x;
		if (x[TW-1]) return '0;
		if (d != '0 && x[TM-1:0] > d) return {1'b0, d};
		return x;
	endfunction

	logic [1:0]    run_q;
	logic [TW-1:0] pos_q;
	logic [31:0]   rev_q, jmp_q;

	logic [3:0]    op_q;
	logic [TW-1:0] t_q, cand_q;
	logic [31:0]   fv_q, frame_q, rev0_q;
	logic          looped_q, ended_q, neg_q, flo_q;
	logic [W-1:0]  acc_q, mc_q, dvd_q;
	logic [23:0]   mp_q;
	logic [DW-1:0] rem_q, dsr_q;
	logic [CW-1:0] cnt_q;

	logic [TM-1:0] lo0, hi0, lo, hi, endp;
	logic          usable, pos_neg, pos_ge_end, cand_neg, wrap_loop, end_hit;
	logic          f_rnz, q_big, t_big, t_all, is_step;
	logic [TW-1:0] home, pos_mag, rel_sum, delta, cand, wrap_y, tick_res;
	logic [TW-1:0] seek_src, seek_y, mod_y;
	logic [31:0]   frame_res;
	logic [32:0]   f33, f_mag;
	logic [12:0]   rate_sat;
	logic [DW:0]   r_sh, r_sub;
	logic          r_ge;
	logic [DW-1:0] rem_next;

	always_comb begin
		lo0        = (ls < le) ? ls : le;
		hi0        = (ls < le) ? le : ls;
		lo         = (dur != '0 && lo0 > dur) ? dur : lo0;
		hi         = (dur != '0 && hi0 > dur) ? dur : hi0;
		usable     = len && (hi > lo);
		home       = usable ? {1'b0, lo} : '0;
		endp       = usable ? hi : dur;
		pos_neg    = pos_q[TW-1];
		pos_ge_end = (endp != '0) && !pos_neg && (pos_q[TM-1:0] >= endp);
		pos_mag    = pos_neg ? (~pos_q + TW'(1)) : pos_q;
		rel_sum    = sat_add(pos_q, t_q);
		delta      = (|acc_q[W-1:8+TM]) ? T_MAX : {1'b0, acc_q[8+TM-1:8]};
		cand       = (op_q == OP_ADVANCE) ? sat_add(pos_q, delta) : t_q;
		cand_neg   = cand[TW-1];
		wrap_loop  = usable && (pos_neg || pos_q[TM-1:0] < hi) && !cand_neg
			&& (cand[TM-1:0] >= hi);
		end_hit    = (dur != '0) && !cand_neg && (cand[TM-1:0] >= dur);
		wrap_y     = clamp_rng(end_hit ? {1'b0, dur} : cand, off, dur);

		f_rnz = (rem_q != '0) || flo_q;
		q_big = |dvd_q[W-1:31];
		if (!pos_neg) frame_res = q_big ? 32'h7fff_ffff : dvd_q[31:0];
		else frame_res = q_big ? 32'h8000_0000 : (~(dvd_q[31:0] + 32'(f_rnz)) + 32'd1);

		t_big = |dvd_q[W-1:TM];
		t_all = &dvd_q[TM-1:0];
		if (!neg_q) tick_res = (t_big || t_all) ? T_MAX : dvd_q[TW-1:0] + TW'(rem_q != '0);
		else tick_res = t_big ? T_MIN : (~dvd_q[TW-1:0] + TW'(1));

		seek_src = (ctl.code == CMD_TFIN) ? tick_res : ((op_q == OP_SEEK_REL) ? rel_sum : t_q);
		seek_y   = clamp_rng(seek_src, off, dur);

		is_step = (op_q == OP_STEP);
		f33     = is_step ? ({frame_q[31], frame_q} + {fv_q[31], fv_q}) : {fv_q[31], fv_q};
		f_mag   = f33[32] ? (~f33 + 33'd1) : f33;

		if (rate < 13'd16) rate_sat = 13'd16;
		else if (rate > 13'd4096) rate_sat = 13'd4096;
		else rate_sat = rate;

		mod_y    = {1'b0, lo} + rem_q[TW-1:0];
		r_sh     = {rem_q, dvd_q[W-1]};
		r_ge     = r_sh >= {1'b0, dsr_q};
		r_sub    = r_sh - {1'b0, dsr_q};
		rem_next = r_ge ? r_sub[DW-1:0] : r_sh[DW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= RUN_STOPPED;
			pos_q <= '0;
			rev_q <= '0;
			jmp_q <= '0;
		end else begin
			case (ctl.code)
				CMD_EXEC: begin
					case (op_q)
						OP_PLAY: begin
							if (run_q != RUN_PLAYING) begin
								if (pos_ge_end) pos_q <= home;
								run_q <= RUN_PLAYING;
								rev_q <= rev_q + 32'd1;
							end
						end
						OP_PAUSE: begin
							if (run_q == RUN_PLAYING) begin
								run_q <= RUN_PAUSED;
								rev_q <= rev_q + 32'd1;
							end
						end
						OP_TOGGLE: begin
							if (run_q == RUN_PLAYING) begin
								run_q <= RUN_PAUSED;
							end else begin
								if (pos_ge_end) pos_q <= home;
								run_q <= RUN_PLAYING;
							end
							rev_q <= rev_q + 32'd1;
						end
						OP_STOP: begin
							if (home != pos_q || run_q != RUN_STOPPED) begin
								run_q <= RUN_STOPPED;
								pos_q <= home;
								rev_q <= rev_q + 32'd1;
							end
						end
						OP_STOP_IN_PLACE: begin
							if (run_q != RUN_STOPPED) begin
								run_q <= RUN_STOPPED;
								rev_q <= rev_q + 32'd1;
							end
						end
						OP_TO_START: begin
							if (home != pos_q) begin
								pos_q <= home;
								rev_q <= rev_q + 32'd1;
							end
						end
						OP_SEEK, OP_SEEK_REL: begin
							if (seek_y != pos_q) begin
								pos_q <= seek_y;
								rev_q <= rev_q + 32'd1;
								jmp_q <= jmp_q + 32'd1;
							end
						end
						OP_OFFLINE_POS: begin
							if (t_q != pos_q) begin
								pos_q <= t_q;
								rev_q <= rev_q + 32'd1;
							end
						end
						default: ;
					endcase
				end
				CMD_TFIN: begin
					if (seek_y != pos_q) begin
						pos_q <= seek_y;
						rev_q <= rev_q + 32'd1;
						jmp_q <= jmp_q + 32'd1;
					end
				end
				CMD_WRAP: begin
					if (!wrap_loop) begin
						if (end_hit) run_q <= RUN_PAUSED;
						pos_q <= wrap_y;
						rev_q <= rev_q + 32'(end_hit) + 32'(wrap_y != pos_q);
					end
				end
				CMD_MFIN: begin
					if (mod_y != pos_q) begin
						pos_q <= mod_y;
						rev_q <= rev_q + 32'd1;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (ctl.code)
			CMD_LOAD: begin
				op_q     <= req.op;
				t_q      <= req.time_value;
				fv_q     <= req.frame_value;
				rev0_q   <= rev_q;
				looped_q <= 1'b0;
				ended_q  <= 1'b0;
			end
			CMD_WRAP: begin
				cand_q <= cand;
				if (wrap_loop) looped_q <= 1'b1;
				else ended_q <= end_hit;
			end
			CMD_FMUL_LD: begin
				acc_q <= '0;
				mc_q  <= W'(pos_mag);
				mp_q  <= num;
			end
			CMD_TMUL_LD: begin
				acc_q <= '0;
				mc_q  <= W'(f_mag);
				mp_q  <= 24'(den);
				neg_q <= f33[32];
			end
			CMD_AMUL_LD: begin
				acc_q <= '0;
				mc_q  <= W'(t_q);
				mp_q  <= 24'(rate_sat);
			end
			CMD_MUL_STEP: begin
				if (mp_q[0]) acc_q <= acc_q + mc_q;
				mc_q <= mc_q << 1;
				mp_q <= mp_q >> 1;
			end
			CMD_FDIV_LD: begin
				dvd_q <= acc_q >> FRAC_BITS;
				flo_q <= |acc_q[FRAC_BITS-1:0];
				dsr_q <= DW'(den);
				rem_q <= '0;
				cnt_q <= CW'(W);
			end
			CMD_TDIV_LD: begin
				dvd_q <= acc_q << FRAC_BITS;
				flo_q <= 1'b0;
				dsr_q <= DW'(num);
				rem_q <= '0;
				cnt_q <= CW'(W);
			end
			CMD_MDIV_LD: begin
				dvd_q <= W'(cand_q - {1'b0, lo});
				flo_q <= 1'b0;
				dsr_q <= DW'(hi - lo);
				rem_q <= '0;
				cnt_q <= CW'(W);
			end
			CMD_DIV_STEP: begin
				rem_q <= rem_next;
				dvd_q <= {dvd_q[W-2:0], r_ge};
				cnt_q <= cnt_q - CW'(1);
			end
			CMD_FFIN: frame_q <= frame_res;
			default: ;
		endcase
	end

	always_comb begin
		sts.mul_done  = (mp_q == '0);
		sts.div_done  = (cnt_q == '0);
		sts.is_step   = is_step;
		sts.is_sfrm   = (op_q == OP_SEEK_FRAME);
		sts.go_adv    = (op_q == OP_ADVANCE) && (run_q == RUN_PLAYING) && !off
			&& !t_q[TW-1] && (t_q != '0);
		sts.go_fol    = (op_q == OP_FOLLOW) && (run_q == RUN_PLAYING) && !off;
		sts.wrap_loop = wrap_loop;
	end

	always_comb begin
		res.play_state  = run_q;
		res.position    = pos_q;
		res.frame_index = frame_q;
		res.changed     = (rev_q != rev0_q);
		res.looped      = looped_q;
		res.reached_end = ended_q;
		res.revision    = rev_q;
		res.jump_count  = jmp_q;
	end

endmodule
`default_nettype wire

[rtl/pht_ctrl.sv]
`default_nettype none
module pht_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cmd_valid,
	output logic              cmd_ready,
	output logic              res_valid,
	input  logic              res_ready,
	output pht_pkg::pht_ctl_t ctl,
	input  pht_pkg::pht_sts_t sts
);
	import pht_pkg::*;

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_EXEC = 4'd1;
	localparam logic [3:0] ST_FMUL = 4'd2;
	localparam logic [3:0] ST_FDIV = 4'd3;
	localparam logic [3:0] ST_FFIN = 4'd4;
	localparam logic [3:0] ST_TMUL = 4'd5;
	localparam logic [3:0] ST_TDIV = 4'd6;
	localparam logic [3:0] ST_TFIN = 4'd7;
	localparam logic [3:0] ST_AMUL = 4'd8;
	localparam logic [3:0] ST_WRAP = 4'd9;
	localparam logic [3:0] ST_MDIV = 4'd10;
	localparam logic [3:0] ST_MFIN = 4'd11;
	localparam logic [3:0] ST_OUT  = 4'd12;

	logic [3:0] st_q, st_n;
	logic       busy_q, busy_n, seek_q, seek_n;

	always_comb begin
		st_n     = st_q;
		busy_n   = busy_q;
		seek_n   = seek_q;
		ctl.code = CMD_NONE;
		case (st_q)
			ST_IDLE: begin
				if (cmd_valid) begin
					ctl.code = CMD_LOAD;
					seek_n   = 1'b0;
					st_n     = ST_EXEC;
				end
			end
			ST_EXEC: begin
				ctl.code = CMD_EXEC;
				if (sts.go_adv) st_n = ST_AMUL;
				else if (sts.go_fol) st_n = ST_WRAP;
				else if (sts.is_sfrm) st_n = ST_TMUL;
				else st_n = ST_FMUL;
			end
			ST_FMUL, ST_TMUL, ST_AMUL: begin
				if (!busy_q) begin
					ctl.code = (st_q == ST_FMUL) ? CMD_FMUL_LD :
						((st_q == ST_TMUL) ? CMD_TMUL_LD : CMD_AMUL_LD);
					busy_n = 1'b1;
				end else if (sts.mul_done) begin
					busy_n = 1'b0;
					st_n   = (st_q == ST_FMUL) ? ST_FDIV :
						((st_q == ST_TMUL) ? ST_TDIV : ST_WRAP);
				end else begin
					ctl.code = CMD_MUL_STEP;
				end
			end
			ST_FDIV, ST_TDIV, ST_MDIV: begin
				if (!busy_q) begin
					ctl.code = (st_q == ST_FDIV) ? CMD_FDIV_LD :
						((st_q == ST_TDIV) ? CMD_TDIV_LD : CMD_MDIV_LD);
					busy_n = 1'b1;
				end else if (sts.div_done) begin
					busy_n = 1'b0;
					st_n   = (st_q == ST_FDIV) ? ST_FFIN :
						((st_q == ST_TDIV) ? ST_TFIN : ST_MFIN);
				end else begin
					ctl.code = CMD_DIV_STEP;
				end
			end
			ST_FFIN: begin
				ctl.code = CMD_FFIN;
				st_n     = (sts.is_step && !seek_q) ? ST_TMUL : ST_OUT;
			end
			ST_TFIN: begin
				ctl.code = CMD_TFIN;
				seek_n   = 1'b1;
				st_n     = ST_FMUL;
			end
			ST_WRAP: begin
				ctl.code = CMD_WRAP;
				st_n     = sts.wrap_loop ? ST_MDIV : ST_FMUL;
			end
			ST_MFIN: begin
				ctl.code = CMD_MFIN;
				st_n     = ST_FMUL;
			end
			ST_OUT: begin
				if (res_ready) st_n = ST_IDLE;
			end
			default: st_n = ST_IDLE;
		endcase
	end

	assign cmd_ready = (st_q == ST_IDLE);
	assign res_valid = (st_q == ST_OUT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= ST_IDLE;
			busy_q <= 1'b0;
			seek_q <= 1'b0;
		end else begin
			st_q   <= st_n;
			busy_q <= busy_n;
			seek_q <= seek_n;
		end
	end

`ifndef SYNTHESIS
	a_ready_result: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd_ready && res_valid)) else $error("request taken while a result is pending");
	a_load_exec: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd_valid && cmd_ready) |=> (st_q == ST_EXEC)) else $error("request not executed");
	a_busy_engine: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (st_q == ST_FMUL || st_q == ST_TMUL || st_q == ST_AMUL ||
		st_q == ST_FDIV || st_q == ST_TDIV || st_q == ST_MDIV))
		else $error("engine busy outside an engine state");
	a_seek_mark: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_TFIN) |=> seek_q) else $error("frame seek not marked done");
`endif

endmodule
`default_nettype wire

[rtl/playhead_transport_with_loop.sv]
`default_nettype none
// Media playhead transport with loop.
// Requests arrive on the cmd channel (valid/ready) carrying an op code, a time value in
// ticks of 2^-FRAC_BITS seconds and a frame value. Each request yields exactly one result
// on the res channel (valid/ready) with the play state, position, frame index, flags and
// the change and jump counters after the request.
// Set-up registers sit on the APB port at byte address 8*i; write them only while idle.
// Requests are handled one at a time. A request is taken in the idle state and executed,
// then the frame index is computed by a shift-add multiplier and a restoring divider of
// one quotient bit per cycle over a W-bit dividend, W = max(TW+24, 49+FRAC_BITS).
// A frame seek adds one more multiply and divide, a frame step two, an advance one
// multiply, and a loop wrap one divide, so the worst case is a frame step.
// The result is held in registers until res_ready; while it waits no request is taken.
// Reset puts the playhead at zero, stopped, with both counters cleared and the registers
// at their reset values.
module playhead_transport_with_loop #(
	parameter int FRAC_BITS = pht_pkg::FRAC_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   psel,
	input  logic                   penable,
	input  logic                   pwrite,
	input  logic [pht_pkg::AW-1:0] paddr,
	input  logic [63:0]            pwdata,
	output logic [63:0]            prdata,
	output logic                   pready,
	input  logic                   cmd_valid,
	output logic                   cmd_ready,
	input  pht_pkg::pht_in_t       cmd,
	output logic                   res_valid,
	input  logic                   res_ready,
	output pht_pkg::pht_out_t      res
);
	import pht_pkg::*;

	logic [TW-2:0] dur, ls, le;
	logic          len, off;
	logic [12:0]   rate;
	logic [23:0]   num;
	logic [15:0]   den;
	pht_ctl_t      ctl;
	pht_sts_t      sts;

	pht_regs u_regs (
		.clk(clk), .arst_n(arst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
		.paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
		.dur(dur), .ls(ls), .le(le), .len(len), .rate(rate), .off(off),
		.num(num), .den(den)
	);

	pht_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .cmd_valid(cmd_valid), .cmd_ready(cmd_ready),
		.res_valid(res_valid), .res_ready(res_ready), .ctl(ctl), .sts(sts)
	);

	pht_dp #(.FRAC_BITS(FRAC_BITS)) u_dp (
		.clk(clk), .arst_n(arst_n), .ctl(ctl), .sts(sts), .req(cmd), .res(res),
		.dur(dur), .ls(ls), .le(le), .len(len), .rate(rate), .off(off),
		.num(num), .den(den)
	);

endmodule
`default_nettype wire
